// ===== hdl/hdlc_bit_stuff_nrzi_framer_unit_macros.svh =====
// Assertion macros used by the port-level checker of the HDLC framer.
// No dependencies.
`ifndef HDLC_BIT_STUFF_NRZI_FRAMER_UNIT_MACROS_SVH
`define HDLC_BIT_STUFF_NRZI_FRAMER_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define HBSN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbsn: next-cycle assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define HBSN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbsn: same-cycle assertion failed");

`endif

// ===== hdl/hbsn_pkg.sv =====
// Types and constants of the HDLC bit-stuffing NRZI framer.
// No dependencies; used by every module of the block.
package hbsn_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_STUFF_SKIP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_FLAG    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_DOWN   = 2'd3;

   localparam logic [5:0] RST_STUFF_SKIP  = 6'd8;
   localparam logic       RST_START_LEVEL = 1'b0;
   localparam logic [7:0] RST_END_FLAG    = 8'h7E;
   localparam logic [2:0] RST_RAMP_DOWN   = 3'd0;

   // A one that arrives with this many ones already in the run gets a stuffed zero.
   localparam logic [2:0] ONES_BEFORE_STUFF = 3'd4;
   // Trailer positions: eight flag bits, then three ramp-down bits.
   localparam logic [3:0] TRAIL_FLAG_LAST = 4'd7;
   localparam logic [3:0] TRAIL_LAST      = 4'd10;

   typedef struct packed {
      logic [5:0] stuff_skip;
      logic       start_level;
      logic [7:0] end_flag;
      logic [2:0] ramp_down;
   } cfg_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_STUFF,
      PH_TRAILER
   } phase_type;

   typedef struct packed {
      logic line_bit;
      logic last_out;
   } line_type;

endpackage

// ===== hdl/hdlc_bit_stuff_nrzi_framer_unit.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_data_bit, req_last_bit
// rsp       out        rsp_valid/rsp_stall   rsp_line_bit, rsp_last_out
// csr       in         csr_write_en          csr_index, csr_write_data
//
// Each input bit produces 1 line bit, 2 with a stuffed zero, and 11 more when it
// closes a frame; one line bit leaves per cycle while rsp is not stalled.
// The sequencer emits into the result register; the next input bit is taken in
// the cycle the held one emits its final line bit. Reset is synchronous and
// leaves the block empty with reset register values. A stall on rsp holds the
// sequencer and, once the holding register is full, raises req_stall.
module hdlc_bit_stuff_nrzi_framer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_data_bit,
   input  logic                             req_last_bit,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_line_bit,
   output logic                             rsp_last_out,
   input  logic                             csr_write_en,
   input  logic [hbsn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbsn_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import hbsn_pkg::*;

   cfg_type  cfg;
   line_type emit;
   logic     hold_valid, hold_data, hold_last;
   logic     out_ready, step, item_done;

   hbsn_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   hbsn_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_bit (req_data_bit),
      .req_last_bit (req_last_bit),
      .release_item (step && item_done),
      .hold_valid   (hold_valid),
      .hold_data    (hold_data),
      .hold_last    (hold_last)
   );

   hbsn_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .hold_valid (hold_valid),
      .hold_data  (hold_data),
      .hold_last  (hold_last),
      .out_ready  (out_ready),
      .step       (step),
      .item_done  (item_done),
      .emit       (emit)
   );

   hbsn_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (step),
      .emit         (emit),
      .out_ready    (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_line_bit (rsp_line_bit),
      .rsp_last_out (rsp_last_out)
   );

endmodule

// ===== hdl/hbsn_csr.sv =====
// Configuration registers of the HDLC framer.
// Depends on hbsn_pkg.
module hbsn_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [hbsn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbsn_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output hbsn_pkg::cfg_type                cfg
);
   import hbsn_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_STUFF_SKIP:  cfg_in.stuff_skip  = csr_write_data[5:0];
            CSR_START_LEVEL: cfg_in.start_level = csr_write_data[0];
            CSR_END_FLAG:    cfg_in.end_flag    = csr_write_data[7:0];
            CSR_RAMP_DOWN:   cfg_in.ramp_down   = csr_write_data[2:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stuff_skip  <= RST_STUFF_SKIP;
         cfg_ff.start_level <= RST_START_LEVEL;
         cfg_ff.end_flag    <= RST_END_FLAG;
         cfg_ff.ramp_down   <= RST_RAMP_DOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/hbsn_in_reg.sv =====
// Input holding register: keeps the current bit until all of its line bits are out.
// Depends on hbsn_pkg.
module hbsn_in_reg (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_data_bit,
   input  logic req_last_bit,
   input  logic release_item,
   output logic hold_valid,
   output logic hold_data,
   output logic hold_last
);
   import hbsn_pkg::*;

   logic hold_valid_ff, hold_valid_in;
   logic hold_data_ff, hold_last_ff;
   logic accept;

   // A new bit can enter in the same cycle the held one emits its final line bit.
   assign req_stall     = hold_valid_ff && !release_item;
   assign accept        = req_valid && !req_stall;
   assign hold_valid_in = accept || (hold_valid_ff && !release_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_data_ff <= req_data_bit;
         hold_last_ff <= req_last_bit;
      end
   end

   assign hold_valid = hold_valid_ff;
   assign hold_data  = hold_data_ff;
   assign hold_last  = hold_last_ff;

endmodule

// ===== hdl/hbsn_seq.sv =====
// Framing sequencer: stuffing, trailer insertion and NRZI line state.
// Depends on hbsn_pkg.
module hbsn_seq (
   input  logic              clock,
   input  logic              reset,
   input  hbsn_pkg::cfg_type cfg,
   input  logic              hold_valid,
   input  logic              hold_data,
   input  logic              hold_last,
   input  logic              out_ready,
   output logic              step,
   output logic              item_done,
   output hbsn_pkg::line_type emit
);
   import hbsn_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] trail_idx_ff, trail_idx_in;
   logic       line_level_ff, line_level_in;
   logic [2:0] ones_run_ff, ones_run_in;
   logic [5:0] bits_seen_ff, bits_seen_in;

   logic       in_skip;
   logic       stuff_needed;
   logic       raw_bit;
   logic       frame_end;
   logic [2:0] flag_sel;
   logic [1:0] ramp_sel;

   assign step         = hold_valid && out_ready;
   assign in_skip      = bits_seen_ff < cfg.stuff_skip;
   assign stuff_needed = !in_skip && hold_data && (ones_run_ff == ONES_BEFORE_STUFF);
   assign flag_sel     = ~trail_idx_ff[2:0];
   assign ramp_sel     = 2'(TRAIL_LAST - trail_idx_ff);
   assign frame_end    = (phase_ff == PH_TRAILER) && (trail_idx_ff == TRAIL_LAST);

   // Next phase and trailer position.
   always_comb begin
      phase_in     = phase_ff;
      trail_idx_in = trail_idx_ff;
      if (step) begin
         case (phase_ff)
            PH_DATA: begin
               trail_idx_in = 4'd0;
               if (stuff_needed) phase_in = PH_STUFF;
               else if (hold_last) phase_in = PH_TRAILER;
            end
            PH_STUFF: begin
               trail_idx_in = 4'd0;
               phase_in     = hold_last ? PH_TRAILER : PH_DATA;
            end
            PH_TRAILER: begin
               if (frame_end) begin
                  phase_in = PH_DATA;
               end else begin
                  trail_idx_in = trail_idx_ff + 4'd1;
               end
            end
            default: phase_in = PH_DATA;
         endcase
      end
   end

   // Emitted bit and item completion.
   always_comb begin
      raw_bit       = 1'b0;
      item_done     = 1'b0;
      emit.last_out = 1'b0;
      case (phase_ff)
         PH_DATA: begin
            raw_bit   = hold_data;
            item_done = !stuff_needed && !hold_last;
         end
         PH_STUFF: begin
            raw_bit   = 1'b0;
            item_done = !hold_last;
         end
         PH_TRAILER: begin
            raw_bit       = (trail_idx_ff <= TRAIL_FLAG_LAST) ? cfg.end_flag[flag_sel]
                                                              : cfg.ramp_down[ramp_sel];
            item_done     = frame_end;
            emit.last_out = frame_end;
         end
         default: begin
            raw_bit   = 1'b0;
            item_done = 1'b0;
         end
      endcase
      // A zero toggles the line, a one keeps it.
      line_level_in = raw_bit ? line_level_ff : !line_level_ff;
      emit.line_bit = line_level_in;
   end

   // Frame counters.
   always_comb begin
      ones_run_in  = ones_run_ff;
      bits_seen_in = bits_seen_ff;
      if (phase_ff == PH_DATA) begin
         if (in_skip) begin
            bits_seen_in = bits_seen_ff + 6'd1;
         end else if (hold_data && !stuff_needed) begin
            ones_run_in = ones_run_ff + 3'd1;
         end else begin
            ones_run_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DATA;
         trail_idx_ff  <= 4'd0;
         line_level_ff <= RST_START_LEVEL;
         ones_run_ff   <= 3'd0;
         bits_seen_ff  <= 6'd0;
      end else begin
         phase_ff     <= phase_in;
         trail_idx_ff <= trail_idx_in;
         if (step) begin
            if (frame_end) begin
               line_level_ff <= cfg.start_level;
               ones_run_ff   <= 3'd0;
               bits_seen_ff  <= 6'd0;
            end else begin
               line_level_ff <= line_level_in;
               ones_run_ff   <= ones_run_in;
               bits_seen_ff  <= bits_seen_in;
            end
         end
      end
   end

endmodule

// ===== hdl/hbsn_out_reg.sv =====
// Result register on the line side of the framer.
// Depends on hbsn_pkg.
module hbsn_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  hbsn_pkg::line_type emit,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_line_bit,
   output logic               rsp_last_out
);
   import hbsn_pkg::*;

   logic     rsp_valid_ff, rsp_valid_in;
   line_type data_ff;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= emit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_line_bit = data_ff.line_bit;
   assign rsp_last_out = data_ff.last_out;

endmodule

// ===== hdl/hbsn_checker.sv =====
// Port-level checks of the HDLC framer, bound to the top level.
// Depends on hdlc_bit_stuff_nrzi_framer_unit_macros.svh.
`include "hdlc_bit_stuff_nrzi_framer_unit_macros.svh"

module hbsn_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_line_bit,
   input logic rsp_last_out
);

   // A stalled result stays put.
   `HBSN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_line_bit) && $stable(rsp_last_out))

   // Reset empties the block: no result and room for an input bit.
   `HBSN_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // A frame has at least eleven trailer bits, so two frame ends never follow each other.
   `HBSN_ASSERT_NEXT(a_frame_gap, clock, reset, rsp_valid && rsp_last_out && !rsp_stall, !(rsp_valid && rsp_last_out))

   // With nothing in flight at the output the input is not held by the line side.
   `HBSN_ASSERT_NOW(a_idle_ready, clock, reset, !req_valid && !rsp_valid && $past(!req_valid && !rsp_valid), !req_stall || $past(req_stall))

endmodule

bind hdlc_bit_stuff_nrzi_framer_unit hbsn_checker u_hbsn_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_line_bit (rsp_line_bit),
   .rsp_last_out (rsp_last_out)
);
